// ----- rtl/core/psd_pkg.sv -----
`timescale 1ns / 1ps
package psd_pkg;

	localparam int CW = 16;
	localparam int DW = 18;
	localparam int DIFF_W = CW + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int RAD_W = PROD_W;
	localparam int ROOT_W = RAD_W / 2;
	localparam int SQ_REM_W = ROOT_W + 2;
	localparam int QUO_W = RAD_W;

	localparam logic [DW-1:0] DIST_LIMIT = DW'(92682);

	typedef enum logic [1:0] {
		REGION_BEFORE = 2'd0,
		REGION_BEYOND = 2'd1,
		REGION_ALONG  = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_END_X   = 2'd2,
		REG_END_Y   = 2'd3
	} reg_index_t;

endpackage

// ----- rtl/core/point_segment_distance_unit.sv -----
`timescale 1ns / 1ps
// A result strobes done once its item has passed 4 arithmetic stages, 17 square
// root stages, 34 divider stages and the output register.
// Throughput: one item per cycle; busy is always low and done is never held off.
// Reset (arst_n low, asynchronous) clears the segment registers to zero and
// drops every valid bit in the pipeline, so no result is left in flight.
module point_segment_distance_unit
	import psd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] point_x,
	input  logic signed [CW-1:0] point_y,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [CW-1:0]        wr_data,
	output logic                 done,
	output logic signed [DW-1:0] distance,
	output logic [1:0]           region
);

	localparam int LATENCY = 4 + ROOT_W + QUO_W + 1;

	// The pipeline never stalls, so the block is always ready for a new item.
	assign busy = 1'b0;

	// Segment endpoint registers, written through the plain write port.
	logic signed [CW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_START_X: start_x_q <= wr_data;
				REG_START_Y: start_y_q <= wr_data;
				REG_END_X:   end_x_q   <= wr_data;
				REG_END_Y:   end_y_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Stage 1: coordinate differences. r = end - start, x = point - start,
	// and q = point - end for the distance to the end point.
	logic                     v_s1;
	logic signed [DIFF_W-1:0] rx_s1, ry_s1, xx_s1, xy_s1, qx_s1, qy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		rx_s1 <= DIFF_W'(end_x_q) - DIFF_W'(start_x_q);
		ry_s1 <= DIFF_W'(end_y_q) - DIFF_W'(start_y_q);
		xx_s1 <= DIFF_W'(point_x) - DIFF_W'(start_x_q);
		xy_s1 <= DIFF_W'(point_y) - DIFF_W'(start_y_q);
		qx_s1 <= DIFF_W'(point_x) - DIFF_W'(end_x_q);
		qy_s1 <= DIFF_W'(point_y) - DIFF_W'(end_y_q);
	end

	// Stage 2: every product the two dot products and the three squared
	// lengths need. Each is one 17 by 17 bit signed multiply.
	logic                     v_s2;
	logic signed [PROD_W-1:0] rxrx_s2, ryry_s2, rxxx_s2, ryxy_s2;
	logic signed [PROD_W-1:0] xxxx_s2, xyxy_s2, qxqx_s2, qyqy_s2, ryxx_s2, rxxy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		rxrx_s2 <= rx_s1 * rx_s1;
		ryry_s2 <= ry_s1 * ry_s1;
		rxxx_s2 <= rx_s1 * xx_s1;
		ryxy_s2 <= ry_s1 * xy_s1;
		xxxx_s2 <= xx_s1 * xx_s1;
		xyxy_s2 <= xy_s1 * xy_s1;
		qxqx_s2 <= qx_s1 * qx_s1;
		qyqy_s2 <= qy_s1 * qy_s1;
		ryxx_s2 <= ry_s1 * xx_s1;
		rxxy_s2 <= rx_s1 * xy_s1;
	end

	// Stage 3: the sums. rr = |r|^2, rd = dot(r,x), nd = dot(n,x) with
	// n = (r.y, -r.x), and the squared distances to both endpoints.
	logic                    v_s3;
	logic signed [SUM_W-1:0] rr_s3, rd_s3, nd_s3, d0_s3, d1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		rr_s3 <= SUM_W'(rxrx_s2) + SUM_W'(ryry_s2);
		rd_s3 <= SUM_W'(rxxx_s2) + SUM_W'(ryxy_s2);
		nd_s3 <= SUM_W'(ryxx_s2) - SUM_W'(rxxy_s2);
		d0_s3 <= SUM_W'(xxxx_s2) + SUM_W'(xyxy_s2);
		d1_s3 <= SUM_W'(qxqx_s2) + SUM_W'(qyqy_s2);
	end

	// Stage 4: region decision. A zero-length segment and a point before the
	// start both take the distance to the start point. The radicand picked
	// here feeds the one shared square root: |r|^2 alongside the segment,
	// otherwise the squared distance to the nearer endpoint.
	logic                    v_s4;
	logic [RAD_W-1:0]        rad_s4;
	logic [QUO_W-1:0]        ndm_s4;
	logic                    neg_s4;
	region_t                 reg_s4;
	region_t                 reg_d;
	logic [RAD_W-1:0]        rad_d;
	logic signed [SUM_W-1:0] nd_abs;

	always_comb begin
		if (rr_s3 == '0 || rd_s3 < 0) begin
			reg_d = REGION_BEFORE;
			rad_d = RAD_W'(d0_s3);
		end else if (rd_s3 > rr_s3) begin
			reg_d = REGION_BEYOND;
			rad_d = RAD_W'(d1_s3);
		end else begin
			reg_d = REGION_ALONG;
			rad_d = RAD_W'(rr_s3);
		end
		nd_abs = (nd_s3 < 0) ? -nd_s3 : nd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		rad_s4 <= rad_d;
		reg_s4 <= reg_d;
		ndm_s4 <= QUO_W'(nd_abs);
		neg_s4 <= (reg_d == REGION_ALONG) && (nd_s3 < 0);
	end

	// Square root: one result bit per stage, two radicand bits consumed per
	// stage by the shift-and-subtract method, which gives the floored root.
	logic                  sq_v   [ROOT_W];
	logic [RAD_W-1:0]      sq_rad [ROOT_W];
	logic [SQ_REM_W-2:0]   sq_rem [ROOT_W];
	logic [ROOT_W-1:0]     sq_root[ROOT_W];
	logic [QUO_W-1:0]      sq_ndm [ROOT_W];
	logic                  sq_neg [ROOT_W];
	region_t               sq_reg [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic                in_v;
		logic [RAD_W-1:0]    in_rad;
		logic [SQ_REM_W-2:0] in_rem;
		logic [ROOT_W-1:0]   in_root;
		logic [QUO_W-1:0]    in_ndm;
		logic                in_neg;
		region_t             in_reg;
		logic [SQ_REM_W-1:0] rem_sh;
		logic [SQ_REM_W-1:0] trial;
		logic                fits;

		if (k == 0) begin : g_first
			assign in_v    = v_s4;
			assign in_rad  = rad_s4;
			assign in_rem  = '0;
			assign in_root = '0;
			assign in_ndm  = ndm_s4;
			assign in_neg  = neg_s4;
			assign in_reg  = reg_s4;
		end else begin : g_next
			assign in_v    = sq_v[k-1];
			assign in_rad  = sq_rad[k-1];
			assign in_rem  = sq_rem[k-1];
			assign in_root = sq_root[k-1];
			assign in_ndm  = sq_ndm[k-1];
			assign in_neg  = sq_neg[k-1];
			assign in_reg  = sq_reg[k-1];
		end

		assign rem_sh = {in_rem[SQ_REM_W-3:0], in_rad[RAD_W-1 -: 2]};
		assign trial  = {in_root, 2'b01};
		assign fits   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k] <= 1'b0;
			else         sq_v[k] <= in_v;
		end

		always_ff @(posedge clk) begin
			sq_rad[k]  <= in_rad << 2;
			sq_rem[k]  <= fits ? (SQ_REM_W-1)'(rem_sh - trial) : (SQ_REM_W-1)'(rem_sh);
			sq_root[k] <= {in_root[ROOT_W-2:0], fits};
			sq_ndm[k]  <= in_ndm;
			sq_neg[k]  <= in_neg;
			sq_reg[k]  <= in_reg;
		end
	end

	// Divider: restoring division of |nd| by the floored length, one quotient
	// bit per stage. Items outside the segment pass through with the root kept
	// as the divisor, and the output stage picks the root for them.
	logic                dv_v  [QUO_W];
	logic [QUO_W-1:0]    dv_num[QUO_W];
	logic [ROOT_W-1:0]   dv_rem[QUO_W];
	logic [QUO_W-1:0]    dv_quo[QUO_W];
	logic [ROOT_W-1:0]   dv_den[QUO_W];
	logic                dv_neg[QUO_W];
	region_t             dv_reg[QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic              in_v;
		logic [QUO_W-1:0]  in_num;
		logic [ROOT_W-1:0] in_rem;
		logic [QUO_W-1:0]  in_quo;
		logic [ROOT_W-1:0] in_den;
		logic              in_neg;
		region_t           in_reg;
		logic [ROOT_W:0]   rem_sh;
		logic              fits;

		if (k == 0) begin : g_first
			assign in_v   = sq_v[ROOT_W-1];
			assign in_num = sq_ndm[ROOT_W-1];
			assign in_rem = '0;
			assign in_quo = '0;
			assign in_den = sq_root[ROOT_W-1];
			assign in_neg = sq_neg[ROOT_W-1];
			assign in_reg = sq_reg[ROOT_W-1];
		end else begin : g_next
			assign in_v   = dv_v[k-1];
			assign in_num = dv_num[k-1];
			assign in_rem = dv_rem[k-1];
			assign in_quo = dv_quo[k-1];
			assign in_den = dv_den[k-1];
			assign in_neg = dv_neg[k-1];
			assign in_reg = dv_reg[k-1];
		end

		assign rem_sh = {in_rem, in_num[QUO_W-1]};
		assign fits   = rem_sh >= {1'b0, in_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k] <= 1'b0;
			else         dv_v[k] <= in_v;
		end

		always_ff @(posedge clk) begin
			dv_num[k] <= in_num << 1;
			dv_rem[k] <= fits ? ROOT_W'(rem_sh - {1'b0, in_den}) : ROOT_W'(rem_sh);
			dv_quo[k] <= {in_quo[QUO_W-2:0], fits};
			dv_den[k] <= in_den;
			dv_neg[k] <= in_neg;
			dv_reg[k] <= in_reg;
		end
	end

	// Output stage: pick quotient or root, clamp to the distance limit and
	// apply the side of the line in the perpendicular case.
	logic [QUO_W-1:0] mag;
	logic [DW-1:0]    mag_clamped;

	always_comb begin
		if (dv_reg[QUO_W-1] == REGION_ALONG) mag = dv_quo[QUO_W-1];
		else                                 mag = QUO_W'(dv_den[QUO_W-1]);
		mag_clamped = (mag > QUO_W'(DIST_LIMIT)) ? DIST_LIMIT : DW'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv_v[QUO_W-1];
	end

	always_ff @(posedge clk) begin
		distance <= dv_neg[QUO_W-1] ? -$signed(mag_clamped) : $signed(mag_clamped);
		region   <= dv_reg[QUO_W-1];
	end

	// Every accepted item comes out with a done strobe once it has passed the whole pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("item did not complete after the pipeline latency");

	// Endpoint distances are never negative.
	a_endpoint_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && region != REGION_ALONG) |-> !distance[DW-1])
		else $error("negative distance outside the segment");

	// Only the perpendicular case carries a sign into the divider.
	a_neg_along: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && neg_s4) |-> (reg_s4 == REGION_ALONG))
		else $error("side sign set outside the segment");

	// A zero-length segment is mapped to the start-point case, so its quotient is never used.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rr_s3 == '0) |=> (reg_s4 == REGION_BEFORE))
		else $error("zero-length segment not mapped to the start point");

endmodule

// ----- verif/tb_point_segment_distance_unit.sv -----
`timescale 1ns / 1ps
module tb_point_segment_distance_unit;
	import psd_pkg::*;

	// The block is a pipeline that takes one query point per cycle.
	localparam int PIPE_LATENCY = 56;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam longint DIST_CAP = 92682;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic                 wr_en;
	logic [1:0]           wr_index;
	logic [CW-1:0]        wr_data;
	logic                 done;
	logic signed [DW-1:0] distance;
	logic [1:0]           region;

	typedef struct packed {
		logic signed [DW-1:0] dist_val;
		region_t              reg_code;
	} answer_t;

	// Segment copy kept by the testbench, updated on every register write.
	logic signed [CW-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
	answer_t              pending_answers[$];
	int                   error_count;
	int                   items_sent;
	int                   answers_seen;
	int                   idle_count;
	int                   send_idle_pct;
	int                   segments_used;

	point_segment_distance_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .distance(distance), .region(region)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Floored integer square root of a non-negative value below 2^72.
	function automatic longint unsigned floor_root(logic [71:0] v);
		logic [71:0] r;
		logic [71:0] t;
		r = '0;
		for (int b = 35; b >= 0; b--) begin
			t = r | (72'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return longint'(r);
	endfunction

	function automatic answer_t predict_distance(logic signed [CW-1:0] px,
			logic signed [CW-1:0] py);
		longint rx, ry, xx, xy, rr, rd, nd, len, q, d;
		answer_t a;
		rx = longint'(seg_ex) - longint'(seg_sx);
		ry = longint'(seg_ey) - longint'(seg_sy);
		xx = longint'(px) - longint'(seg_sx);
		xy = longint'(py) - longint'(seg_sy);
		rr = rx * rx + ry * ry;
		rd = rx * xx + ry * xy;
		if (rr == 0 || rd < 0) begin
			d = floor_root(72'(xx * xx + xy * xy));
			a.reg_code = REGION_BEFORE;
		end else if (rd > rr) begin
			xx = longint'(px) - longint'(seg_ex);
			xy = longint'(py) - longint'(seg_ey);
			d = floor_root(72'(xx * xx + xy * xy));
			a.reg_code = REGION_BEYOND;
		end else begin
			// Signed side distance: magnitude quotient, truncated toward zero.
			nd = ry * xx - rx * xy;
			len = floor_root(72'(rr));
			q = (nd < 0 ? -nd : nd) / len;
			if (q > DIST_CAP)
				q = DIST_CAP;
			d = nd < 0 ? -q : q;
			a.reg_code = REGION_ALONG;
		end
		if (d > DIST_CAP)
			d = DIST_CAP;
		a.dist_val = DW'(d);
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (answer %0d)", what, got, want,
			answers_seen);
		error_count++;
	endtask

	// Results cannot be held off, so every done pulse is checked right away.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result, distance", distance, 0);
			end else begin
				want = pending_answers.pop_front();
				if (distance !== want.dist_val)
					report_mismatch("distance", distance, want.dist_val);
				if (region !== want.reg_code)
					report_mismatch("region", region, want.reg_code);
			end
		end
	end

	// Watchdog: cycles with nothing accepted on either side.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("point_segment_distance_unit test failed");
				$finish;
			end
		end
	end

	// Drives one register write for a cycle; the caller drops the write enable.
	task automatic write_segment_reg(reg_index_t idx, logic [CW-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_START_X: seg_sx = val;
			REG_START_Y: seg_sy = val;
			REG_END_X:   seg_ex = val;
			default:     seg_ey = val;
		endcase
	endtask

	// Waits until every result is back plus the pipeline depth, then loads a segment.
	task automatic load_segment(logic [CW-1:0] sx, logic [CW-1:0] sy,
			logic [CW-1:0] ex, logic [CW-1:0] ey);
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		write_segment_reg(REG_START_X, sx);
		write_segment_reg(REG_START_Y, sy);
		write_segment_reg(REG_END_X, ex);
		write_segment_reg(REG_END_Y, ey);
		wr_en <= 1'b0;
		segments_used++;
	endtask

	// Sends one query point; idle gaps are inserted ahead of it at random.
	// Start stays high after the item so back to back items need no gap.
	task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_answers.push_back(predict_distance(px, py));
		items_sent++;
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CW'($urandom);
			1: return CW'($signed($urandom_range(512)) - 256);
			2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return CW'($signed($urandom_range(8192)) - 4096);
		endcase
	endfunction

	task automatic test_reset_segment();
		// Registers at reset give a zero-length segment at the origin.
		send_point(16'h0000, 16'h0000);
		send_point(16'h7fff, 16'h7fff);
		send_point(16'h8000, 16'h8000);
		send_point(16'h8000, 16'h7fff);
	endtask

	task automatic test_directed_regions();
		load_segment(16'hff00, 16'h0000, 16'h0100, 16'h0000);
		send_point(16'hfe00, 16'h0000);  // before start
		send_point(16'h0200, 16'h0100);  // beyond end
		send_point(16'h0000, 16'h0100);  // alongside, one side
		send_point(16'h0000, 16'hff00);  // alongside, other side
		send_point(16'h0100, 16'h0000);  // exactly at the end point
		send_point(16'hff00, 16'h0000);  // exactly at the start point
		// Extreme segment corner to corner.
		load_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_point(16'h8000, 16'h7fff);
		send_point(16'h7fff, 16'h8000);
		send_point(16'h0000, 16'h0000);
		// Very short segment: the floored length is tiny, so the quotients are large.
		load_segment(16'h0000, 16'h0000, 16'h0001, 16'h0000);
		send_point(16'h0000, 16'h7fff);
		send_point(16'h0000, 16'h8000);
		send_point(16'h0001, 16'h0000);
		// Zero-length segment away from the origin.
		load_segment(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_point(16'h8000, 16'h7fff);
		send_point(16'h7fff, 16'h8000);
	endtask

	task automatic test_random_phase(int idle_pct, int n);
		send_idle_pct = idle_pct;
		for (int s = 0; s < n / 50; s++) begin
			if ($urandom_range(9) == 0)
				load_segment(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
			else
				load_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			for (int i = 0; i < 50; i++)
				send_point(rand_coord(), rand_coord());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		seg_sx = '0;
		seg_sy = '0;
		seg_ex = '0;
		seg_ey = '0;
		error_count = 0;
		items_sent = 0;
		answers_seen = 0;
		idle_count = 0;
		send_idle_pct = 0;
		segments_used = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_segment();
		test_directed_regions();
		test_random_phase(0, 300);
		test_random_phase(88, 250);
		test_random_phase(0, 250);
		test_random_phase(27, 250);

		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		$display("Covered %0d query points over %0d segments, %0d results checked.",
			items_sent, segments_used, answers_seen);
		$display("Phases: back to back, sparse sender, and light sender gaps.");
		if (error_count == 0 && pending_answers.size() == 0) begin
			$display("point_segment_distance_unit test passed");
		end else begin
			$display("point_segment_distance_unit test failed");
		end
		$finish;
	end

endmodule
